// ===== src/srrc_pkg.sv =====
// Package for the score run ratio classifier.
// Holds field widths, register indexes, verdict codes and the multiplier interface structs.
// No dependencies.
package srrc_pkg;

    localparam int SCORE_W   = 16;
    localparam int COUNT_W   = 13;
    localparam int TOTAL_W   = 28;
    localparam int RUN_W     = 12;
    localparam int RATIO_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int DEC_W     = 2;

    // Shared multiplier: 57-bit product, 16-bit multiplier, one bit per cycle.
    localparam int PROD_W    = 57;
    localparam int MUL_B_W   = 16;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOW_RUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Q8    = 2'd2;

    localparam logic [DEC_W-1:0] DEC_EMPTY     = 2'd0;
    localparam logic [DEC_W-1:0] DEC_NO_HIGH   = 2'd1;
    localparam logic [DEC_W-1:0] DEC_SHORT_RUN = 2'd2;
    localparam logic [DEC_W-1:0] DEC_RATIO     = 2'd3;

    typedef struct packed {
        logic start;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// ===== src/score_run_ratio_classifier_top.sv =====
// Top level of the score run ratio classifier.
// Accumulates window scores and sequences the final ratio compare; depends on srrc_pkg, srrc_mul.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+--------------------------------------
//  in       | in_valid / in_ready | score[15:0], skip, last
//  out      | out_valid/out_ready | verdict, decided_by[1:0]
//  cfg      | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[15:0]
//
// A request that is not last is taken in the idle state and updates the counts and totals.
// A last request goes from the decide state straight to delivery when the verdict is settled
// without arithmetic; when the averages are compared, it waits on the shared shift-and-add
// multiplier, which retires one multiplier bit per cycle over three 16-step products.
// Input is not taken while a verdict is being worked out, nor while a finished verdict waits
// behind an earlier one that the output side has not yet taken.
// Reset clears the registers, counts and totals at once; there is no clearing pass.
module score_run_ratio_classifier_top
    import srrc_pkg::*;
#(
    parameter int SCORE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SCORE_W-1:0]   score,
    input  logic                 skip,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 verdict,
    output logic [DEC_W-1:0]     decided_by,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Only the low SCORE_BITS bits of a score take part, and never more than the port carries.
    localparam int UsedBits = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;
    localparam logic [SCORE_W-1:0] ScoreMask = {SCORE_W{1'b1}} >> (SCORE_W - UsedBits);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LHS,
        ST_RHS_A,
        ST_RHS_B,
        ST_DELIVER
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [SCORE_W-1:0] low_level_reg;
    logic [RUN_W-1:0]   min_low_run_reg;
    logic [RATIO_W-1:0] ratio_q8_reg;

    // Sequence state.
    logic [COUNT_W-1:0] low_count_reg;
    logic [TOTAL_W-1:0] low_total_reg;
    logic [COUNT_W-1:0] high_count_reg;
    logic [TOTAL_W-1:0] high_total_reg;
    logic               seen_any_reg;

    // Verdict working registers and the output register.
    logic [PROD_W-1:0]  lhs_reg;
    logic               res_verdict_reg;
    logic [DEC_W-1:0]   res_dec_reg;
    logic               out_valid_reg;
    logic               verdict_reg;
    logic [DEC_W-1:0]   decided_by_reg;

    // Multiplier operands, launched in the cycle after they are chosen.
    logic               mul_start_reg;
    logic [PROD_W-1:0]  mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    mul_ctrl_t          mul_ctrl;
    mul_stat_t          mul_stat;
    logic [PROD_W-1:0]  mul_prod;

    logic               in_take;
    logic [SCORE_W-1:0] score_used;
    logic               is_low;
    logic               short_run;
    logic [TOTAL_W:0]   low_sum;
    logic [TOTAL_W:0]   high_sum;
    logic [COUNT_W-1:0] low_count_inc;
    logic [COUNT_W-1:0] high_count_inc;
    logic [TOTAL_W-1:0] low_total_add;
    logic [TOTAL_W-1:0] high_total_add;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign score_used = score & ScoreMask;
    assign is_low     = (score_used <= low_level_reg);
    // A low run shorter than the minimum; used both at a high score and at the verdict.
    assign short_run  = (low_count_reg < COUNT_W'(min_low_run_reg));

    // Saturating updates of the counts and totals.
    assign low_sum  = {1'b0, low_total_reg} + (TOTAL_W + 1)'(score_used);
    assign high_sum = {1'b0, high_total_reg} + (TOTAL_W + 1)'(score_used);
    assign low_total_add  = low_sum[TOTAL_W] ? TOTAL_MAX : low_sum[TOTAL_W-1:0];
    assign high_total_add = high_sum[TOTAL_W] ? TOTAL_MAX : high_sum[TOTAL_W-1:0];
    assign low_count_inc  = (low_count_reg == COUNT_MAX) ? COUNT_MAX : low_count_reg + 1'b1;
    assign high_count_inc = (high_count_reg == COUNT_MAX) ? COUNT_MAX : high_count_reg + 1'b1;

    assign mul_ctrl.start = mul_start_reg;

    srrc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mul_ctrl),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            low_level_reg   <= '0;
            min_low_run_reg <= '0;
            ratio_q8_reg    <= '0;
            low_count_reg   <= '0;
            low_total_reg   <= '0;
            high_count_reg  <= '0;
            high_total_reg  <= '0;
            seen_any_reg    <= 1'b0;
            lhs_reg         <= '0;
            res_verdict_reg <= 1'b0;
            res_dec_reg     <= DEC_EMPTY;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= 1'b0;
            decided_by_reg  <= DEC_EMPTY;
            mul_start_reg   <= 1'b0;
            mul_a_reg       <= '0;
            mul_b_reg       <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LOW_LEVEL:   low_level_reg   <= cfg_data;
                    CFG_MIN_LOW_RUN: min_low_run_reg <= cfg_data[RUN_W-1:0];
                    CFG_RATIO_Q8:    ratio_q8_reg    <= cfg_data[RATIO_W-1:0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        if (!skip)
                        begin
                            seen_any_reg <= 1'b1;
                            if (is_low)
                            begin
                                low_count_reg <= low_count_inc;
                                low_total_reg <= low_total_add;
                            end
                            else
                            begin
                                high_count_reg <= high_count_inc;
                                high_total_reg <= high_total_add;
                                if (short_run)
                                begin
                                    low_count_reg <= '0;
                                end
                            end
                        end
                        if (last)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end

                ST_DECIDE:
                begin
                    priority if (!seen_any_reg)
                    begin
                        res_verdict_reg <= 1'b0;
                        res_dec_reg     <= DEC_EMPTY;
                        state_reg       <= ST_DELIVER;
                    end
                    else if (high_count_reg == '0)
                    begin
                        res_verdict_reg <= 1'b1;
                        res_dec_reg     <= DEC_NO_HIGH;
                        state_reg       <= ST_DELIVER;
                    end
                    else if (short_run)
                    begin
                        res_verdict_reg <= 1'b1;
                        res_dec_reg     <= DEC_SHORT_RUN;
                        state_reg       <= ST_DELIVER;
                    end
                    else if (low_count_reg == '0)
                    begin
                        // No low average to compare against: the compare fails.
                        res_verdict_reg <= 1'b0;
                        res_dec_reg     <= DEC_RATIO;
                        state_reg       <= ST_DELIVER;
                    end
                    else
                    begin
                        // First product: high_total * low_count.
                        mul_a_reg     <= PROD_W'(high_total_reg);
                        mul_b_reg     <= MUL_B_W'(low_count_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_LHS;
                    end
                end

                ST_LHS:
                begin
                    if (mul_stat.done)
                    begin
                        // The left side carries the Q8.8 scale of the ratio.
                        lhs_reg       <= {mul_prod[PROD_W-9:0], 8'b0};
                        mul_a_reg     <= PROD_W'(low_total_reg);
                        mul_b_reg     <= ratio_q8_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RHS_A;
                    end
                end

                ST_RHS_A:
                begin
                    if (mul_stat.done)
                    begin
                        mul_a_reg     <= mul_prod;
                        mul_b_reg     <= MUL_B_W'(high_count_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_RHS_B;
                    end
                end

                ST_RHS_B:
                begin
                    if (mul_stat.done)
                    begin
                        res_verdict_reg <= (lhs_reg < mul_prod);
                        res_dec_reg     <= DEC_RATIO;
                        state_reg       <= ST_DELIVER;
                    end
                end

                ST_DELIVER:
                begin
                    // Wait until the output register is free, then start a fresh sequence.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        verdict_reg    <= res_verdict_reg;
                        decided_by_reg <= res_dec_reg;
                        low_count_reg  <= '0;
                        low_total_reg  <= '0;
                        high_count_reg <= '0;
                        high_total_reg <= '0;
                        seen_any_reg   <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign decided_by = decided_by_reg;

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |-> !mul_stat.busy)
        else $error("multiplier started while still busy");

    a_empty_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && decided_by == DEC_EMPTY) |-> !verdict)
        else $error("empty sequence reported as passing");

    a_early_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (decided_by == DEC_NO_HIGH || decided_by == DEC_SHORT_RUN)) |-> verdict)
        else $error("early decision reported as failing");

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input taken while a verdict is pending");

    a_high_total_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (high_count_reg == '0) |-> (high_total_reg == '0))
        else $error("high total without any high score");
`endif

endmodule

// ===== src/srrc_mul.sv =====
// Shift-and-add multiplier shared by the ratio compare.
// Retires one multiplier bit per cycle; depends on srrc_pkg.
module srrc_mul
    import srrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mul_ctrl_t           ctrl,
    input  logic [PROD_W-1:0]   a,
    input  logic [MUL_B_W-1:0]  b,
    output mul_stat_t           stat,
    output logic [PROD_W-1:0]   prod
);

    logic [PROD_W-1:0]    a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [PROD_W-1:0]    acc_next;

    assign acc_next = acc_reg + (b_reg[0] ? a_reg : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            a_reg   <= {a_reg[PROD_W-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

// ===== dv/srrc_verdict_checker.sv =====
// Checker for the score run ratio classifier: watches the request, verdict and register channels.
// Predicts each verdict from its own copy of the thresholds and accumulators and compares it.
// Depends on srrc_pkg for widths, register indexes and decision codes.
`timescale 1ns / 1ps

module srrc_verdict_checker
    import srrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [SCORE_W-1:0]   score,
    input  logic                 skip,
    input  logic                 last,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 verdict,
    input  logic [DEC_W-1:0]     decided_by,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic             ok;
        logic [DEC_W-1:0] reason;
    } verdict_t;

    // Thresholds as last written.
    logic [SCORE_W-1:0] level;
    logic [RUN_W-1:0]   run_min;
    logic [RATIO_W-1:0] ratio;

    // Accumulators of the sequence in progress.
    logic [COUNT_W-1:0] n_low;
    logic [COUNT_W-1:0] n_high;
    logic [TOTAL_W-1:0] sum_low;
    logic [TOTAL_W-1:0] sum_high;
    logic               any_window;

    verdict_t verdict_q[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_sequence();
        n_low      = '0;
        n_high     = '0;
        sum_low    = '0;
        sum_high   = '0;
        any_window = 1'b0;
    endfunction

    // Folds one window into the accumulators; returns 1 with the verdict when the
    // window closes its sequence.
    function automatic bit take_window(input logic [SCORE_W-1:0] s, input logic sk,
                                       input logic lst, output verdict_t v);
        logic [TOTAL_W:0] sum;
        logic [63:0]      lhs;
        logic [63:0]      rhs;
        v = '0;
        if (!sk)
        begin
            any_window = 1'b1;
            if (s <= level)
            begin
                if (n_low != COUNT_MAX)
                    n_low = n_low + 1'b1;
                sum = sum_low + s;
                sum_low = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
            else
            begin
                if (n_high != COUNT_MAX)
                    n_high = n_high + 1'b1;
                sum = sum_high + s;
                sum_high = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                // A low run that is still too short is forgotten, but its total is kept.
                if (n_low < run_min)
                    n_low = '0;
            end
        end
        if (!lst)
            return 1'b0;

        if (!any_window)
        begin
            v.ok     = 1'b0;
            v.reason = DEC_EMPTY;
        end
        else if (n_high == '0)
        begin
            v.ok     = 1'b1;
            v.reason = DEC_NO_HIGH;
        end
        else if (n_low < run_min)
        begin
            v.ok     = 1'b1;
            v.reason = DEC_SHORT_RUN;
        end
        else
        begin
            v.reason = DEC_RATIO;
            if (n_low == '0)
                v.ok = 1'b0;
            else
            begin
                // Averages compared by cross-multiplication, ratio in Q8.8.
                lhs = sum_high;
                lhs = lhs * n_low;
                lhs = lhs * 256;
                rhs = sum_low;
                rhs = rhs * ratio;
                rhs = rhs * n_high;
                v.ok = (lhs < rhs);
            end
        end
        clear_sequence();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            level   = '0;
            run_min = '0;
            ratio   = '0;
            clear_sequence();
            verdict_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOW_LEVEL:   level   = cfg_data;
                    CFG_MIN_LOW_RUN: run_min = cfg_data[RUN_W-1:0];
                    CFG_RATIO_Q8:    ratio   = cfg_data;
                    default:         ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("verdict %0b/%0d with none pending",
                                              verdict, decided_by));
                else
                begin
                    want = verdict_q.pop_front();
                    if (verdict !== want.ok)
                        report_mismatch($sformatf("verdict %0b, predicted %0b",
                                                  verdict, want.ok));
                    if (decided_by !== want.reason)
                        report_mismatch($sformatf("decided_by %0d, predicted %0d",
                                                  decided_by, want.reason));
                end
            end

            if (in_valid && in_ready)
            begin
                if (take_window(score, skip, last, got))
                    verdict_q = {verdict_q, got};
            end

            outstanding <= verdict_q.size();
        end
    end

endmodule

// ===== dv/tb_score_run_ratio_classifier_top.sv =====
// Testbench top for the score run ratio classifier: clock, reset, stimulus and final verdict.
// Prediction and comparison live in srrc_verdict_checker; depends on srrc_pkg and the block.
`timescale 1ns / 1ps

module tb_score_run_ratio_classifier_top;
    import srrc_pkg::*;

    // A spare register index; writes to it must leave every threshold alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // The limit leaves ample room for a correct run even if every request closed
    // a sequence with a ratio compare under the longest stalls on both sides.
    localparam int CYCLE_LIMIT  = 400000;
    // Long enough to cover any verdict still in flight, a ratio compare included.
    localparam int DRAIN_CYCLES = 80;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [SCORE_W-1:0]   score = '0;
    logic                 skip = 1'b0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 verdict;
    logic [DEC_W-1:0]     decided_by;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int cycles = 0;

    // When set, neither side idles: the requests go in back to back and the verdicts
    // are taken the moment they appear.
    logic calm = 1'b0;

    // Low level currently programmed, so that random scores can be placed around it.
    logic [SCORE_W-1:0] level_now = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    score_run_ratio_classifier_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .score      (score),
        .skip       (skip),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .verdict    (verdict),
        .decided_by (decided_by),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    srrc_verdict_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .score       (score),
        .skip        (skip),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .verdict     (verdict),
        .decided_by  (decided_by),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // The output side stalls in roughly one cycle in six, except during calm stretches.
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 16);
    end

    // Watchdog: a hung handshake or a lost verdict ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one window and returns at the edge where it is taken, with valid still high
    // so that the next request can follow without a gap. Valid is only lowered when an idle
    // gap is chosen, so it never sees two assignments in one step.
    task automatic offer_window(input logic [SCORE_W-1:0] s, input logic sk, input logic lst);
        if (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        in_valid <= 1'b1;
        score    <= s;
        skip     <= sk;
        last     <= lst;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Register writes go back to back; the caller lowers valid after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Programs all three thresholds. The run length is padded with random upper bits,
    // which the block must drop, and the spare index gets a random write as well.
    task automatic set_thresholds(input logic [SCORE_W-1:0] ll, input logic [RUN_W-1:0] mr,
                                  input logic [RATIO_W-1:0] rq);
        logic [CFG_DAT_W-RUN_W-1:0] junk;
        junk = (CFG_DAT_W - RUN_W)'($urandom_range(15));
        write_reg(CFG_UNUSED, CFG_DAT_W'($urandom_range(65535)));
        write_reg(CFG_LOW_LEVEL, ll);
        write_reg(CFG_MIN_LOW_RUN, {junk, mr});
        write_reg(CFG_RATIO_Q8, rq);
        cfg_valid <= 1'b0;
        level_now = ll;
    endtask

    // Stops offering and waits until every predicted verdict has been taken. The first
    // edge lets the checker record a request taken at the edge we were called on.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Scores are mostly placed just either side of the low level, where the low and high
    // runs interleave, with some extremes and some anywhere in range.
    function automatic logic [SCORE_W-1:0] pick_score(input logic [SCORE_W-1:0] lvl);
        int r;
        int d;
        int v;
        r = $urandom_range(99);
        d = $urandom_range(40);
        if (r < 35)
            v = int'(lvl) - d;
        else if (r < 70)
            v = int'(lvl) + 1 + d;
        else if (r < 80)
            v = $urandom_range(1) ? 65535 : 0;
        else
            v = $urandom_range(65535);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[SCORE_W-1:0];
    endfunction

    // One sequence of random windows. Now and then every window is skipped, and any
    // window, the closing one included, may be skipped on its own.
    task automatic random_sequence(input int len);
        bit hollow;
        hollow = ($urandom_range(19) == 0);
        for (int i = 0; i < len; i++)
            offer_window(pick_score(level_now), hollow || ($urandom_range(99) < 12),
                         i == len - 1);
    endtask

    initial
    begin : stimulus
        logic [SCORE_W-1:0] ll;
        logic [RUN_W-1:0]   mr;
        logic [RATIO_W-1:0] rq;
        int                 sent;
        int                 len;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Low level 100, runs of two survive, ratio 1.0.
        set_thresholds(16'd100, 12'd2, 16'd256);
        // An empty sequence, first as a lone skipped request, then with two.
        offer_window(16'd0, 1'b1, 1'b1);
        offer_window(16'hFFFF, 1'b1, 1'b0);
        offer_window(16'd0, 1'b1, 1'b1);
        // Only low scores, including one exactly at the level.
        offer_window(16'd0, 1'b0, 1'b0);
        offer_window(16'd100, 1'b0, 1'b0);
        offer_window(16'd50, 1'b0, 1'b1);
        // A high score cuts a single low window, leaving a short run at the end.
        offer_window(16'd10, 1'b0, 1'b0);
        offer_window(16'd200, 1'b0, 1'b0);
        offer_window(16'd5, 1'b0, 1'b1);
        // The low total survives the cut and feeds the ratio compare.
        offer_window(16'd90, 1'b0, 1'b0);
        offer_window(16'd200, 1'b0, 1'b0);
        offer_window(16'd10, 1'b0, 1'b0);
        offer_window(16'd10, 1'b0, 1'b0);
        offer_window(16'd101, 1'b0, 1'b1);
        settle();

        // No run needed, widest ratio: a compare with no low window at all, then a
        // sequence closed by a skipped request whose score must be ignored.
        set_thresholds(16'd100, 12'd0, 16'hFFFF);
        offer_window(16'hFFFF, 1'b0, 1'b1);
        offer_window(16'd100, 1'b0, 1'b0);
        offer_window(16'd101, 1'b0, 1'b0);
        offer_window(16'd7, 1'b1, 1'b1);
        settle();

        // Lowest level, longest run requirement, zero ratio.
        set_thresholds(16'd0, 12'hFFF, 16'd0);
        offer_window(16'd0, 1'b0, 1'b0);
        offer_window(16'hFFFF, 1'b0, 1'b1);
        settle();

        // Highest level: every score is low.
        set_thresholds(16'hFFFF, 12'd1, 16'd0);
        offer_window(16'hFFFF, 1'b0, 1'b1);
        settle();

        // A zero ratio makes a compare that is reached fail.
        set_thresholds(16'd100, 12'd1, 16'd0);
        offer_window(16'd50, 1'b0, 1'b0);
        offer_window(16'd200, 1'b0, 1'b1);
        settle();

        // One longer sequence of large scores, sent with no idling on either side.
        set_thresholds(16'h7FFF, 12'd0, 16'd257);
        calm <= 1'b1;
        for (int i = 0; i < 40; i++)
            offer_window(i[0] ? 16'hFFFF : 16'h7FFF, 1'b0, 1'b0);
        offer_window(16'd0, 1'b1, 1'b1);
        settle();
        calm <= 1'b0;

        // Random part: ten settings, the extremes first, about forty requests each.
        // Short run requirements and modest ratios keep most verdicts on the compare.
        for (int p = 0; p < 10; p++)
        begin
            if (p == 0)
                set_thresholds(16'd0, 12'd0, 16'hFFFF);
            else if (p == 1)
                set_thresholds(16'hFFFF, 12'hFFF, 16'd0);
            else
            begin
                ll = SCORE_W'($urandom_range(65535));
                mr = ($urandom_range(4) == 0) ? RUN_W'($urandom_range(4095))
                                              : RUN_W'($urandom_range(3));
                rq = ($urandom_range(4) == 0) ? RATIO_W'($urandom_range(65535))
                                              : RATIO_W'($urandom_range(768));
                set_thresholds(ll, mr, rq);
            end
            calm <= (p == 5);
            sent = 0;
            while (sent < 40)
            begin
                len = $urandom_range(1, 12);
                random_sequence(len);
                sent += len;
            end
            settle();
        end
        calm <= 1'b0;

        // Everything has been taken; give any stray verdict time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
